/* hdl/mpc_pkg.sv */
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the move-to-front palette coder
// Transfer payloads, opcodes, group geometry of the cell chain and the
// control bundle that the top level broadcasts to every group of cells.
// ----------------------------------------------------------------------------
package mpc_pkg;

  // Palette geometry
  localparam int unsigned PaletteDepth = 338;
  localparam int unsigned CountWidth   = 9;
  localparam int unsigned DistWidth    = 9;
  localparam int unsigned InColorWidth = 32;

  // Cells are grouped; each group resolves its own match prefix
  localparam int unsigned GroupBits    = 4;
  localparam int unsigned GroupSize    = 1 << GroupBits;
  localparam int unsigned NumGroups    = (PaletteDepth + GroupSize - 1) / GroupSize;
  localparam int unsigned GroupIdxBits = DistWidth - GroupBits;

  // Code class boundaries on the distance and reference points on the count
  localparam int unsigned Class1Base = 2;
  localparam int unsigned Class2Base = 18;
  localparam int unsigned Class3Base = 82;
  localparam int unsigned Class3Ref  = 83;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_DECODE = 2'd1,
    OP_INSERT = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CLASS_NEAR = 2'd0,
    CLASS_MID  = 2'd1,
    CLASS_FAR  = 2'd2,
    CLASS_REST = 2'd3
  } code_class_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [InColorWidth-1:0] color;
    logic [DistWidth-1:0]   distance;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic [DistWidth-1:0]    distance_out;
    logic [1:0]              code_class;
    logic [3:0]              index_bits;
    logic [InColorWidth-1:0] color_out;
    logic                    fault;
    logic [CountWidth-1:0]   entries_used;
  } out_item_t;

  // Control broadcast from the sequencer to the groups and cells
  typedef struct packed {
    logic                  fetch_en;
    logic [GroupBits-1:0]  rd_sel;
    logic                  cmp_en;
    logic                  pfx_en;
    logic                  shift_all;
    logic                  shift_hit;
    logic [CountWidth-1:0] count;
  } cell_ctrl_t;

endpackage

/* hdl/mtf_palette_coder.sv */
// ----------------------------------------------------------------------------
// mtf_palette_coder: move-to-front colour palette cache
// Encode, decode, literal insert and clear over a palette held in a chain
// of cells ordered by distance from the newest entry.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                            | Direction | Moves
//  --------+------------------------------------+-----------+------------------------
//  in      | in_valid_i in_ready_o in_data_i    | into core | opcode, colour, distance
//  out     | out_valid_o out_ready_i out_data_o | out       | one result per item
//
//  The sequencer takes an item only while idle and walks the cell chain for
//  it: compare in every cell, group prefix, group-level prefix, then one
//  shift of the chain; decode first reads the entry out through the group
//  registers, insert only shifts, and clear and an out-of-range decode go
//  straight to the result. The result enters the output register as the
//  sequencer returns to idle, ready for the next input transfer.
//  Reset clears the sequencer, the fill count and the output valid; the
//  palette itself is undefined until written. A new item is taken while a
//  result waits in the output register; the next result then holds until
//  the output side takes the waiting one.
// ----------------------------------------------------------------------------
module mtf_palette_coder #(
  parameter int unsigned COLOR_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mpc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mpc_pkg::out_item_t   out_data_o
);

  localparam int unsigned NG  = mpc_pkg::NumGroups;
  localparam int unsigned CNW = mpc_pkg::CountWidth;
  localparam int unsigned DW  = mpc_pkg::DistWidth;
  localparam int unsigned GB  = mpc_pkg::GroupBits;
  localparam int unsigned GIB = mpc_pkg::GroupIdxBits;
  localparam logic [CNW-1:0] DepthVal = CNW'(mpc_pkg::PaletteDepth);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SEL,
    S_CMP,
    S_PFX,
    S_PFX2,
    S_APPLY,
    S_DONE
  } state_e;

  state_e                  state_q;
  mpc_pkg::opcode_e        op_q;
  logic [COLOR_WIDTH-1:0]  key_q;
  logic [COLOR_WIDTH-1:0]  col_q;
  logic [DW-1:0]           dist_q;
  logic [DW-1:0]           dout_q;
  logic [CNW-1:0]          n_q;
  logic [CNW-1:0]          count_q;
  logic                    hit_q;
  logic                    fault_q;
  logic [NG-1:0]           before_q;
  logic                    out_valid_q;
  mpc_pkg::out_item_t      out_q;

  mpc_pkg::cell_ctrl_t     ctrl;
  logic [COLOR_WIDTH-1:0]  chain_w [NG+1];
  logic [COLOR_WIDTH-1:0]  rd_w    [NG];
  logic [GB-1:0]           first_w [NG];
  logic [NG-1:0]           any_w;
  logic [NG-1:0]           before_d;
  logic [DW-1:0]           found_d;
  logic                    in_fire;
  logic                    out_free;
  logic [COLOR_WIDTH-1:0]  in_col;
  mpc_pkg::out_item_t      res_d;

  // Least i with v below two to the i; zero for v not above zero
  function automatic logic [3:0] min_bits(input logic signed [CNW:0] v);
    logic [3:0] r;
    r = '0;
    if (v > 0) begin
      for (int i = 0; i < CNW; i++) begin
        if (v[i]) begin
          r = 4'(i + 1);
        end
      end
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_col     = in_data_i.color[COLOR_WIDTH-1:0];

  // Broadcast control for the cell chain
  always_comb begin
    ctrl           = '0;
    ctrl.count     = count_q;
    ctrl.rd_sel    = dist_q[GB-1:0];
    ctrl.fetch_en  = (state_q == S_FETCH);
    ctrl.cmp_en    = (state_q == S_CMP);
    ctrl.pfx_en    = (state_q == S_PFX);
    ctrl.shift_all = (state_q == S_APPLY) && !hit_q;
    ctrl.shift_hit = (state_q == S_APPLY) && hit_q;
  end

  // Newest slot takes the key; every other cell takes its neighbour
  assign chain_w[0] = key_q;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    mpc_group #(
      .COLOR_WIDTH (COLOR_WIDTH),
      .BASE        (g * mpc_pkg::GroupSize)
    ) u_grp (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .before_i   (before_q[g]),
      .key_i      (key_q),
      .chain_i    (chain_w[g]),
      .chain_o    (chain_w[g+1]),
      .any_o      (any_w[g]),
      .first_o    (first_w[g]),
      .rd_color_o (rd_w[g])
    );
  end

  // Group-level prefix: which groups lie past the nearest match
  always_comb begin
    found_d = '0;
    for (int g = 0; g < NG; g++) begin
      before_d[g] = |(any_w & ((NG'(1) << g) - NG'(1)));
    end
    for (int g = 0; g < NG; g++) begin
      if (any_w[g] && !before_d[g]) begin
        found_d = found_d | {GIB'(g), first_w[g]};
      end
    end
  end

  // Result word from the settled item state
  always_comb begin
    logic [3:0] b1;
    logic [3:0] b2;
    logic [3:0] b3;
    b1 = min_bits($signed({1'b0, n_q}) - (CNW+1)'(mpc_pkg::Class1Base));
    b2 = min_bits($signed({1'b0, n_q}) - (CNW+1)'(mpc_pkg::Class2Base));
    b3 = min_bits($signed({1'b0, n_q}) - (CNW+1)'(mpc_pkg::Class3Ref));
    res_d              = '0;
    res_d.hit          = hit_q;
    res_d.fault        = fault_q;
    res_d.entries_used = count_q;
    res_d.color_out    = mpc_pkg::InColorWidth'(col_q);
    if (hit_q) begin
      res_d.distance_out = dout_q;
      if (op_q == mpc_pkg::OP_DECODE) begin
        res_d.color_out = mpc_pkg::InColorWidth'(key_q);
      end
      priority if (dout_q < DW'(mpc_pkg::Class1Base)) begin
        res_d.code_class = mpc_pkg::CLASS_NEAR;
        res_d.index_bits = 4'd1;
      end else if (dout_q < DW'(mpc_pkg::Class2Base)) begin
        res_d.code_class = mpc_pkg::CLASS_MID;
        res_d.index_bits = (b1 > 4'd4) ? 4'd4 : b1;
      end else if (dout_q < DW'(mpc_pkg::Class3Base)) begin
        res_d.code_class = mpc_pkg::CLASS_FAR;
        res_d.index_bits = (b2 > 4'd6) ? 4'd6 : b2;
      end else begin
        res_d.code_class = mpc_pkg::CLASS_REST;
        res_d.index_bits = b3;
      end
    end
  end

  // Control registers: sequencer, fill count and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      before_q    <= '0;
    end else begin
      // Drop valid after the output transfer unless a new result replaces it
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            hit_q <= (in_data_i.opcode == mpc_pkg::OP_DECODE) &&
                     (in_data_i.distance < count_q);
            unique case (in_data_i.opcode)
              mpc_pkg::OP_ENCODE: state_q <= S_CMP;
              mpc_pkg::OP_DECODE: begin
                if (in_data_i.distance >= count_q) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_FETCH;
                end
              end
              mpc_pkg::OP_INSERT: state_q <= S_APPLY;
              mpc_pkg::OP_CLEAR: begin
                count_q <= '0;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_FETCH: state_q <= S_SEL;
        S_SEL:   state_q <= S_CMP;
        S_CMP:   state_q <= S_PFX;
        S_PFX:   state_q <= S_PFX2;
        S_PFX2: begin
          // Hold the found state; decode always finds its fetched colour
          before_q <= before_d;
          hit_q    <= |any_w;
          state_q  <= S_APPLY;
        end
        S_APPLY: begin
          if (!hit_q && (count_q < DepthVal)) begin
            count_q <= count_q + CNW'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= in_data_i.opcode;
      key_q   <= in_col;
      col_q   <= in_col;
      dist_q  <= in_data_i.distance;
      dout_q  <= (in_data_i.opcode == mpc_pkg::OP_DECODE) ? in_data_i.distance : '0;
      n_q     <= count_q;
      fault_q <= (in_data_i.opcode == mpc_pkg::OP_DECODE) &&
                 (in_data_i.distance >= count_q);
    end
    if (state_q == S_SEL) begin
      key_q <= rd_w[dist_q[DW-1:GB]];
    end
    if ((state_q == S_PFX2) && (op_q == mpc_pkg::OP_ENCODE)) begin
      dout_q <= found_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/mpc_cell.sv */
// ----------------------------------------------------------------------------
// mpc_cell: one palette entry of the chain
// Holds one colour, compares it with the key and takes its neighbour's
// colour when told to shift.
// ----------------------------------------------------------------------------
module mpc_cell #(
  parameter int unsigned COLOR_WIDTH = 32,
  parameter int unsigned INDEX       = 0
) (
  input  logic                      clk_i,
  input  mpc_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      shift_i,
  input  logic [COLOR_WIDTH-1:0]    key_i,
  input  logic [COLOR_WIDTH-1:0]    prev_i,
  output logic [COLOR_WIDTH-1:0]    color_o,
  output logic                      match_o
);

  localparam logic [mpc_pkg::CountWidth-1:0] IndexVal = mpc_pkg::CountWidth'(INDEX);

  logic [COLOR_WIDTH-1:0] color_q;
  logic                   match_q;
  logic                   live;

  // Entry is live when its distance lies below the fill count
  assign live = IndexVal < ctrl_i.count;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      color_q <= prev_i;
    end
    if (ctrl_i.cmp_en) begin
      match_q <= live && (color_q == key_i);
    end
  end

  assign color_o = color_q;
  assign match_o = match_q;

endmodule

/* hdl/mpc_group.sv */
// ----------------------------------------------------------------------------
// mpc_group: a run of chained cells
// Resolves the nearest match inside the run, drives the per-cell shift
// enables and reads one entry out for decode.
// ----------------------------------------------------------------------------
module mpc_group #(
  parameter int unsigned COLOR_WIDTH = 32,
  parameter int unsigned BASE        = 0
) (
  input  logic                              clk_i,
  input  mpc_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              before_i,
  input  logic [COLOR_WIDTH-1:0]            key_i,
  input  logic [COLOR_WIDTH-1:0]            chain_i,
  output logic [COLOR_WIDTH-1:0]            chain_o,
  output logic                              any_o,
  output logic [mpc_pkg::GroupBits-1:0]     first_o,
  output logic [COLOR_WIDTH-1:0]            rd_color_o
);

  localparam int unsigned GS = mpc_pkg::GroupSize;
  localparam int unsigned NumCells =
    (mpc_pkg::PaletteDepth - BASE < GS) ? (mpc_pkg::PaletteDepth - BASE) : GS;

  logic [COLOR_WIDTH-1:0]          color_w [GS];
  logic [GS-1:0]                   match_w;
  logic [GS-1:0]                   excl_d;
  logic [GS-1:0]                   excl_q;
  logic [mpc_pkg::GroupBits-1:0]   first_d;
  logic [mpc_pkg::GroupBits-1:0]   first_q;
  logic                            any_q;
  logic [COLOR_WIDTH-1:0]          rd_q;

  for (genvar j = 0; j < GS; j++) begin : g_cell
    if (j < NumCells) begin : g_real
      logic shift;
      assign shift = ctrl_i.shift_all ||
                     (ctrl_i.shift_hit && !before_i && !excl_q[j]);
      mpc_cell #(
        .COLOR_WIDTH (COLOR_WIDTH),
        .INDEX       (BASE + j)
      ) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl_i),
        .shift_i (shift),
        .key_i   (key_i),
        .prev_i  ((j == 0) ? chain_i : color_w[(j == 0) ? 0 : j-1]),
        .color_o (color_w[j]),
        .match_o (match_w[j])
      );
    end else begin : g_pad
      assign color_w[j] = '0;
      assign match_w[j] = 1'b0;
    end
  end

  // Exclusive prefix of matches and index of the nearest one
  always_comb begin
    first_d = '0;
    for (int j = 0; j < GS; j++) begin
      excl_d[j] = |(match_w & ((GS'(1) << j) - GS'(1)));
    end
    for (int j = 0; j < GS; j++) begin
      if (match_w[j] && !excl_d[j]) begin
        first_d = first_d | mpc_pkg::GroupBits'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pfx_en) begin
      excl_q  <= excl_d;
      any_q   <= |match_w;
      first_q <= first_d;
    end
    if (ctrl_i.fetch_en) begin
      rd_q <= color_w[ctrl_i.rd_sel];
    end
  end

  assign chain_o    = color_w[NumCells-1];
  assign any_o      = any_q;
  assign first_o    = first_q;
  assign rd_color_o = rd_q;

endmodule

/* verif/mtf_palette_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtf_palette_checker: scoreboard for the move-to-front palette coder
// Watches both channels, keeps its own copy of the palette and the fill
// count, works out the result of every input transfer and compares each
// output transfer, field by field, with the oldest result still awaited.
// ----------------------------------------------------------------------------
module mtf_palette_checker #(
  parameter int unsigned ColorWidth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mpc_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mpc_pkg::out_item_t  out_data_i,
  output int unsigned         err_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         hit_cnt_o,
  output int unsigned         fault_cnt_o,
  output int unsigned         evict_cnt_o
);

  localparam logic [31:0] ColorMask = 32'hFFFF_FFFF >> (32 - ColorWidth);

  // Oldest colour at index 0, newest at fill_q-1
  logic [31:0]         shade_q [mpc_pkg::PaletteDepth];
  int                  fill_q;
  mpc_pkg::out_item_t  awaited_q [$];
  mpc_pkg::out_item_t  want, got, res;

  // least i with v < 2**i, zero for v <= 0
  function automatic int bit_len(input int v);
    int b;
    b = 0;
    while (v > 0) begin
      v = v >> 1;
      b++;
    end
    return b;
  endfunction

  function automatic void classify(input int d, input int n,
                                   output logic [1:0] cls, output logic [3:0] bits);
    int b;
    if (d < int'(mpc_pkg::Class1Base)) begin
      cls  = mpc_pkg::CLASS_NEAR;
      bits = 4'd1;
    end else if (d < int'(mpc_pkg::Class2Base)) begin
      b    = bit_len(n - int'(mpc_pkg::Class1Base));
      cls  = mpc_pkg::CLASS_MID;
      bits = 4'((b < 4) ? b : 4);
    end else if (d < int'(mpc_pkg::Class3Base)) begin
      b    = bit_len(n - int'(mpc_pkg::Class2Base));
      cls  = mpc_pkg::CLASS_FAR;
      bits = 4'((b < 6) ? b : 6);
    end else begin
      cls  = mpc_pkg::CLASS_REST;
      bits = 4'(bit_len(n - int'(mpc_pkg::Class3Ref)));
    end
  endfunction

  function automatic int nearest(input logic [31:0] c);
    for (int i = fill_q - 1; i >= 0; i--) begin
      if (shade_q[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void move_to_front(input int pos);
    logic [31:0] keep;
    if (pos < 0 || pos >= fill_q) return;
    keep = shade_q[pos];
    for (int i = pos; i + 1 < fill_q; i++) shade_q[i] = shade_q[i+1];
    shade_q[fill_q-1] = keep;
  endfunction

  // Append, or drop the oldest when full
  function automatic void append(input logic [31:0] c);
    if (fill_q < int'(mpc_pkg::PaletteDepth)) begin
      shade_q[fill_q] = c;
      fill_q++;
    end else begin
      for (int i = 0; i + 1 < fill_q; i++) shade_q[i] = shade_q[i+1];
      shade_q[fill_q-1] = c;
      evict_cnt_o++;
    end
  endfunction

  task automatic run_palette_op(input mpc_pkg::in_item_t it,
                                output mpc_pkg::out_item_t r);
    logic [31:0] col;
    logic [31:0] pick;
    int          pos;
    int          n;
    col         = it.color & ColorMask;
    n           = fill_q;
    r           = '0;
    r.color_out = col;
    case (it.opcode)
      mpc_pkg::OP_ENCODE: begin
        pos = nearest(col);
        if (pos >= 0) begin
          r.hit          = 1'b1;
          r.distance_out = mpc_pkg::DistWidth'(n - 1 - pos);
          classify(n - 1 - pos, n, r.code_class, r.index_bits);
          move_to_front(pos);
        end else begin
          append(col);
        end
      end
      mpc_pkg::OP_DECODE: begin
        if (int'(it.distance) >= n) begin
          r.fault = 1'b1;
        end else begin
          r.hit          = 1'b1;
          r.distance_out = it.distance;
          classify(int'(it.distance), n, r.code_class, r.index_bits);
          pick        = shade_q[n - 1 - int'(it.distance)];
          r.color_out = pick;
          move_to_front(nearest(pick));
        end
      end
      mpc_pkg::OP_INSERT: append(col);
      default:            fill_q = 0;
    endcase
    r.entries_used = mpc_pkg::CountWidth'(fill_q);
    if (r.hit) hit_cnt_o++;
    if (r.fault) fault_cnt_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      = 0;
      awaited_q.delete();
      err_cnt_o   = 0;
      pending_o   = 0;
      results_o   = 0;
      hit_cnt_o   = 0;
      fault_cnt_o = 0;
      evict_cnt_o = 0;
    end else begin
      // Retire the output transfer first; a new item cannot answer in this cycle
      if (out_valid_i && out_ready_i) begin
        results_o++;
        got = out_data_i;
        if (awaited_q.size() == 0) begin
          $error("result with none awaited: %h", got);
          err_cnt_o++;
        end else begin
          want = awaited_q.pop_front();
          check_field("hit",          32'(want.hit),          32'(got.hit));
          check_field("distance_out", 32'(want.distance_out), 32'(got.distance_out));
          check_field("code_class",   32'(want.code_class),   32'(got.code_class));
          check_field("index_bits",   32'(want.index_bits),   32'(got.index_bits));
          check_field("color_out",    32'(want.color_out),    32'(got.color_out));
          check_field("fault",        32'(want.fault),        32'(got.fault));
          check_field("entries_used", 32'(want.entries_used), 32'(got.entries_used));
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_palette_op(in_data_i, res);
        awaited_q.push_back(res);
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the move-to-front palette coder
// Drives a short directed sequence and then episodes of random operations
// over colour pools of several sizes, with bursty input and a stalling
// output side; the checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ColorWidth = 32;
  localparam int          RandItems  = 2000;
  // Slowest correct run is roughly 0.4 ms for 2k items at a 4 ns clock
  localparam int          TimeoutNs  = 2_000_000;
  localparam int          DrainLimit = 20_000;
  localparam int          TailCycles = 24;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mpc_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mpc_pkg::out_item_t  out_data;

  int unsigned err_cnt, pending, results, hit_cnt, fault_cnt, evict_cnt;

  // Sender burst state
  int burst_left = 0;
  int sent       = 0;

  // Receiver stall pattern: rotate a word, reload it now and then
  logic [31:0] ready_pat  = '1;
  int          pat_left   = 0;

  mtf_palette_coder #(
    .COLOR_WIDTH (ColorWidth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  mtf_palette_checker #(
    .ColorWidth (ColorWidth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .results_o   (results),
    .hit_cnt_o   (hit_cnt),
    .fault_cnt_o (fault_cnt),
    .evict_cnt_o (evict_cnt)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest correct run
  initial begin
    #(TimeoutNs);
    $display("testbench: errors");
    $finish;
  end

  // Receiver: mostly-ready, mostly-stalled, random or never-stalling phases.
  // One bit of each word is forced high so no word stalls the output side throughout.
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = '1;
        1:       ready_pat = $urandom();
        2:       ready_pat = $urandom() | $urandom();
        default: ready_pat = $urandom() & $urandom() & $urandom();
      endcase
      ready_pat[$urandom_range(0, 31)] = 1'b1;
      pat_left = $urandom_range(32, 256);
    end
    out_ready <= ready_pat[0];
    ready_pat  = {ready_pat[0], ready_pat[31:1]};
    pat_left--;
  end

  function automatic mpc_pkg::in_item_t mk_item(input mpc_pkg::opcode_e op,
                                                input logic [31:0] c,
                                                input logic [mpc_pkg::DistWidth-1:0] d);
    mpc_pkg::in_item_t it;
    it.opcode   = op;
    it.color    = c;
    it.distance = d;
    return it;
  endfunction

  // Offer one item and hold it until the transfer. At the start of a burst,
  // drop valid for a random gap first; within a burst keep valid high and
  // only swap the payload, so valid never sees two assignments in one step.
  task automatic push(input mpc_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  initial begin
    logic [31:0]        pool [512];
    int                 pool_n;
    int                 ep_len;
    int                 roll;
    int                 rand_sent;
    mpc_pkg::in_item_t  it;

    rand_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty decode, extreme colours, nearest-copy lookups with
    // duplicates, decode at and past the fill count, clear and reuse.
    push(mk_item(mpc_pkg::OP_DECODE, 32'h0000_0000, 9'd0));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'h0000_0000, 9'd0));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'hFFFF_FFFF, 9'h1FF));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'h0000_0000, 9'd0));
    push(mk_item(mpc_pkg::OP_INSERT, 32'hFFFF_FFFF, 9'd0));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'hFFFF_FFFF, 9'd0));
    push(mk_item(mpc_pkg::OP_DECODE, 32'h1234_5678, 9'd2));
    push(mk_item(mpc_pkg::OP_DECODE, 32'hA5A5_A5A5, 9'd3));
    push(mk_item(mpc_pkg::OP_DECODE, 32'h5A5A_5A5A, 9'd337));
    push(mk_item(mpc_pkg::OP_DECODE, 32'h0F0F_0F0F, 9'd1));
    push(mk_item(mpc_pkg::OP_INSERT, 32'hA5A5_A5A5, 9'h0AA));
    push(mk_item(mpc_pkg::OP_INSERT, 32'h5A5A_5A5A, 9'h155));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'hA5A5_A5A5, 9'd0));
    push(mk_item(mpc_pkg::OP_DECODE, 32'h0000_0000, 9'd0));
    push(mk_item(mpc_pkg::OP_CLEAR,  32'hDEAD_BEEF, 9'd5));
    push(mk_item(mpc_pkg::OP_DECODE, 32'h0000_0001, 9'd0));
    push(mk_item(mpc_pkg::OP_ENCODE, 32'hFFFF_FFFF, 9'd0));
    push(mk_item(mpc_pkg::OP_CLEAR,  32'h8000_0000, 9'h100));

    // Random: episodes over one colour pool each. Large pools fill the
    // palette and force eviction and the far classes; small pools keep
    // hitting near the front.
    for (int ep = 0; rand_sent < RandItems; ep++) begin
      case (ep % 3)
        0:       pool_n = $urandom_range(300, 480);
        1:       pool_n = $urandom_range(2, 16);
        default: pool_n = $urandom_range(17, 120);
      endcase
      for (int k = 0; k < pool_n; k++) pool[k] = $urandom();
      if ($urandom_range(0, 3) == 0) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      ep_len = (ep % 3 == 0) ? $urandom_range(800, 1000) : $urandom_range(150, 400);

      for (int k = 0; k < ep_len && rand_sent < RandItems; k++) begin
        roll        = $urandom_range(0, 99);
        it.color    = ($urandom_range(0, 9) == 0) ? $urandom()
                                                  : pool[$urandom_range(0, pool_n - 1)];
        it.distance = ($urandom_range(0, 2) == 0)
                      ? mpc_pkg::DistWidth'($urandom_range(0, 337))
                      : mpc_pkg::DistWidth'($urandom_range(0, 24));
        if (roll < 50)                        it.opcode = mpc_pkg::OP_ENCODE;
        else if (roll < 78)                   it.opcode = mpc_pkg::OP_DECODE;
        else if (roll < 99 || ep % 3 == 0)    it.opcode = mpc_pkg::OP_INSERT;
        else                                  it.opcode = mpc_pkg::OP_CLEAR;
        push(it);
        rand_sent++;
      end
      // Usually start the next pool from an empty palette
      if ($urandom_range(0, 3) != 0) begin
        push(mk_item(mpc_pkg::OP_CLEAR, $urandom(),
                     mpc_pkg::DistWidth'($urandom_range(0, 337))));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every awaited result, then a tail for strays
    for (int c = 0; c < DrainLimit && pending != 0; c++) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);

    $display("run covered %0d items in, %0d results compared", sent, results);
    $display("  %0d hits, %0d out-of-range decodes, %0d evictions", hit_cnt,
             fault_cnt, evict_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mpc_pkg.sv
hdl/mpc_cell.sv
hdl/mpc_group.sv
hdl/mtf_palette_coder.sv
verif/mtf_palette_checker.sv
verif/testbench.sv
